// File: rtl/core/dpwm_pkg.sv
package dpwm_pkg;

   // page geometry
   localparam int PAGE_SHIFT   = 12;
   localparam int ADDR_W       = 32;
   localparam int PAGE_W       = ADDR_W - PAGE_SHIFT;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // default table depth
   localparam int DEF_TABLE_ENTRIES = 64;

   // window register reset values
   localparam logic [PAGE_W-1:0] WINDOW_START_RST = 20'hE0000;
   localparam logic [PAGE_W-1:0] WINDOW_END_RST   = 20'hF0000;

   // register indexes (byte address bit 2)
   typedef enum logic {
      REG_WINDOW_START = 1'b0,
      REG_WINDOW_END   = 1'b1
   } reg_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_HIT       = 2'd0,
      STAT_NEW       = 2'd1,
      STAT_EXHAUSTED = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_EMIT
   } state_type;

endpackage

// File: rtl/core/dpwm_ram.sv
module dpwm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/device_page_window_mapper.sv
// Sequence: an accepted item is compared against the table entries in order;
//   a hit goes straight to the output stage, a miss goes through allocation first.
// A new item is taken only once the last result has moved on to the output
//   register, which holds it while rsp_stall is high; the table is scanned
//   one entry per cycle through the single read port of the table RAM.
// Reset: window registers return to their defaults, entry and page counters
//   clear; table contents are not cleared (only written entries are read).
module device_page_window_mapper #(
   parameter int TABLE_ENTRIES = dpwm_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dpwm_pkg::ADDR_W-1:0]         req_phys_addr,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dpwm_pkg::ADDR_W-1:0]         rsp_virt_addr,
   output logic [dpwm_pkg::PAGE_W-1:0]         rsp_mapped_phys_page,
   output dpwm_pkg::status_type                rsp_status,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dpwm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dpwm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dpwm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import dpwm_pkg::*;

   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENTRY_W = 2 * PAGE_W;

   state_type             state_ff, state_in;

   logic [PAGE_W-1:0]     win_start_ff, win_end_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PAGE_W-1:0]     alloc_ff, alloc_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  dvld_ff, dvld_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [PAGE_SHIFT-1:0] offset_ff, offset_in;

   // finished result waiting for the output register
   logic [ADDR_W-1:0]     res_virt_ff, res_virt_in;
   logic [PAGE_W-1:0]     res_ppage_ff, res_ppage_in;
   status_type            res_status_ff, res_status_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_virt_ff, rsp_virt_in;
   logic [PAGE_W-1:0]     rsp_ppage_ff, rsp_ppage_in;
   status_type            rsp_status_ff, rsp_status_in;

   // table RAM signals
   logic                  ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_wr_data, ram_rd_data;
   logic [PAGE_W-1:0]     rd_tag, rd_wpage;

   logic                  csr_wr;
   logic [PAGE_W:0]       next_page;
   logic                  issue;
   logic                  hit;

   // table: physical page tag in the upper half, window page in the lower
   dpwm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_tag   = ram_rd_data[ENTRY_W-1:PAGE_W];
   assign rd_wpage = ram_rd_data[PAGE_W-1:0];

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= WINDOW_START_RST;
         win_end_ff   <= WINDOW_END_RST;
      end else if (csr_wr) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_WINDOW_START: win_start_ff <= csr_pwdata[PAGE_W-1:0];
            REG_WINDOW_END:   win_end_ff   <= csr_pwdata[PAGE_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_WINDOW_START: csr_prdata = CSR_DATA_W'(win_start_ff);
         REG_WINDOW_END:   csr_prdata = CSR_DATA_W'(win_end_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // handshakes
   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_virt_addr        = rsp_virt_ff;
   assign rsp_mapped_phys_page = rsp_ppage_ff;
   assign rsp_status           = rsp_status_ff;

   // scan compare and allocation arithmetic
   assign issue     = (scan_ff < count_ff);
   assign hit       = dvld_ff && (rd_tag == page_ff);
   assign next_page = {1'b0, win_start_ff} + {1'b0, alloc_ff};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         alloc_ff     <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         alloc_ff     <= alloc_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      page_ff       <= page_in;
      offset_ff     <= offset_in;
      res_virt_ff   <= res_virt_in;
      res_ppage_ff  <= res_ppage_in;
      res_status_ff <= res_status_in;
      rsp_virt_ff   <= rsp_virt_in;
      rsp_ppage_ff  <= rsp_ppage_in;
      rsp_status_ff <= rsp_status_in;
   end

   // sequencer: next state and datapath controls
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      alloc_in      = alloc_ff;
      scan_in       = scan_ff;
      dvld_in       = 1'b0;
      page_in       = page_ff;
      offset_in     = offset_ff;
      res_virt_in   = res_virt_ff;
      res_ppage_in  = res_ppage_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_virt_in   = rsp_virt_ff;
      rsp_ppage_in  = rsp_ppage_ff;
      rsp_status_in = rsp_status_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_ff[IDX_W-1:0];
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IDX_W-1:0];
      ram_wr_data   = {page_ff, next_page[PAGE_W-1:0]};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in   = req_phys_addr[ADDR_W-1:PAGE_SHIFT];
               offset_in = req_phys_addr[PAGE_SHIFT-1:0];
               scan_in   = '0;
               state_in  = S_SCAN;
            end
         end

         // one read issued and one tag compared per cycle
         S_SCAN: begin
            if (hit) begin
               res_virt_in   = {rd_wpage, offset_ff};
               res_ppage_in  = '0;
               res_status_in = STAT_HIT;
               state_in      = S_EMIT;
            end else if (issue) begin
               ram_rd_en = 1'b1;
               scan_in   = scan_ff + 1'b1;
               dvld_in   = 1'b1;
            end else begin
               state_in = S_ALLOC;
            end
         end

         // miss: append a new pair or report why not
         S_ALLOC: begin
            priority if (count_ff == CNT_W'(TABLE_ENTRIES)) begin
               res_virt_in   = '0;
               res_ppage_in  = '0;
               res_status_in = STAT_FULL;
            end else if (next_page >= {1'b0, win_end_ff}) begin
               res_virt_in   = '0;
               res_ppage_in  = '0;
               res_status_in = STAT_EXHAUSTED;
            end else begin
               ram_wr_en     = 1'b1;
               count_in      = count_ff + 1'b1;
               alloc_in      = alloc_ff + 1'b1;
               res_virt_in   = {next_page[PAGE_W-1:0], offset_ff};
               res_ppage_in  = page_ff;
               res_status_in = STAT_NEW;
            end
            state_in = S_EMIT;
         end

         // hand the result to the output register once it is free
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_virt_in   = res_virt_ff;
               rsp_ppage_in  = res_ppage_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: bench/device_page_window_mapper_test.sv
`timescale 1ns / 1ps

module device_page_window_mapper_test;
   import dpwm_pkg::*;

   localparam int TABLE_DEPTH    = DEF_TABLE_ENTRIES;
   localparam int QUIET_LIMIT    = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 54;
   localparam int DIRECTED_COUNT = 28;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {WIN_SMALL, WIN_WIDE, WIN_INVERTED, WIN_RANDOM} window_plan_type;
   typedef enum logic [1:0] {
      FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH
   } flow_plan_type;

   typedef struct packed {
      logic [ADDR_W-1:0] virt;
      logic [PAGE_W-1:0] page;
      status_type        status;
   } map_result_type;

   typedef struct packed {
      row_kind_type      kind;
      reg_index_type     reg_idx;
      logic [ADDR_W-1:0] value;
      logic              typed;
      map_result_type    want;
   } stim_row_type;

   // directed rows: typed results only where obvious, the rest go to the predictor
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // first mappings at the reset window
      '{ROW_ITEM,  REG_WINDOW_START, 32'h0000_0000, 1'b1, '{32'hE000_0000, 20'h00000, STAT_NEW}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h0000_0FFF, 1'b1, '{32'hE000_0FFF, 20'h00000, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'hFFFF_FFFF, 1'b1, '{32'hE000_1FFF, 20'hFFFFF, STAT_NEW}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'hFFFF_F000, 1'b1, '{32'hE000_1000, 20'h00000, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h1234_5678, 1'b1, '{32'hE000_2678, 20'h12345, STAT_NEW}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'hA5A5_A5A5, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h5A5A_5A5A, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      // window just used up, hit still wins
      '{ROW_WRITE, REG_WINDOW_START, 32'h0000_0010, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_WRITE, REG_WINDOW_END,   32'h0000_0015, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'hABCD_E123, 1'b1, '{32'h0, 20'h0, STAT_EXHAUSTED}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h1234_5ABC, 1'b1, '{32'hE000_2ABC, 20'h0, STAT_HIT}},
      // one more page opens up
      '{ROW_WRITE, REG_WINDOW_END,   32'h0000_0016, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'hABCD_E123, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'hABCD_E000, 1'b1, '{32'h0001_5000, 20'h0, STAT_HIT}},
      // end below start, then top of page range where the sum must not wrap
      '{ROW_WRITE, REG_WINDOW_START, 32'h000F_FFFF, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_WRITE, REG_WINDOW_END,   32'h0000_0000, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h0BAD_F00D, 1'b1, '{32'h0, 20'h0, STAT_EXHAUSTED}},
      '{ROW_WRITE, REG_WINDOW_END,   32'h000F_FFFF, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h0BAD_F00D, 1'b1, '{32'h0, 20'h0, STAT_EXHAUSTED}},
      '{ROW_WRITE, REG_WINDOW_START, 32'h000F_FFF8, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h0BAD_F00D, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h7FFF_FFFF, 1'b1, '{32'h0, 20'h0, STAT_EXHAUSTED}},
      // empty window at zero, then the widest window
      '{ROW_WRITE, REG_WINDOW_START, 32'h0000_0000, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_WRITE, REG_WINDOW_END,   32'h0000_0000, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h8000_0000, 1'b1, '{32'h0, 20'h0, STAT_EXHAUSTED}},
      '{ROW_WRITE, REG_WINDOW_END,   32'h000F_FFFF, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h8000_0000, 1'b0, '{32'h0, 20'h0, STAT_HIT}},
      '{ROW_ITEM,  REG_WINDOW_START, 32'h0000_0001, 1'b1, '{32'hE000_0001, 20'h0, STAT_HIT}}
   };

   localparam window_plan_type WINDOW_PLAN [PHASES] = '{
      WIN_SMALL, WIN_WIDE, WIN_INVERTED, WIN_RANDOM, WIN_WIDE, WIN_SMALL, WIN_WIDE, WIN_RANDOM
   };
   localparam flow_plan_type FLOW_PLAN [PHASES] = '{
      FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH,
      FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH
   };

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [ADDR_W-1:0]     req_phys_addr = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [ADDR_W-1:0]     rsp_virt_addr;
   logic [PAGE_W-1:0]     rsp_mapped_phys_page;
   status_type            rsp_status;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // own copy of the mapping table, counters and window registers
   logic [PAGE_W-1:0] known_phys_pages [TABLE_DEPTH];
   logic [PAGE_W-1:0] known_window_pages [TABLE_DEPTH];
   int                mapped_entries;
   logic [PAGE_W-1:0] pages_handed_out;
   logic [PAGE_W-1:0] window_start_cfg;
   logic [PAGE_W-1:0] window_end_cfg;

   map_result_type pending_maps [$];
   int             mismatch_count;
   int             items_sent;
   int             register_writes;
   int             status_seen [4];
   int unsigned    sender_idle_pct;
   int unsigned    receiver_stall_pct;
   int unsigned    quiet_cycles;

   device_page_window_mapper u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // expected mapping for one address, updates the table copy on a new page
   function automatic map_result_type map_page(input logic [ADDR_W-1:0] addr);
      logic [PAGE_W-1:0] page;
      logic [PAGE_W:0]   next_page;
      map_result_type    r;
      bit                found;
      page     = addr[ADDR_W-1:PAGE_SHIFT];
      r.virt   = '0;
      r.page   = '0;
      r.status = STAT_HIT;
      found    = 1'b0;
      // table search comes first, so a hit beats full and exhausted
      for (int k = 0; k < mapped_entries; k++) begin
         if (!found && known_phys_pages[k] == page) begin
            found  = 1'b1;
            r.virt = {known_window_pages[k], addr[PAGE_SHIFT-1:0]};
         end
      end
      if (!found) begin
         // next page is start plus count, one bit wider so it never wraps
         next_page = {1'b0, window_start_cfg} + {1'b0, pages_handed_out};
         if (mapped_entries >= TABLE_DEPTH) begin
            r.status = STAT_FULL;
         end else if (next_page >= {1'b0, window_end_cfg}) begin
            r.status = STAT_EXHAUSTED;
         end else begin
            known_phys_pages[mapped_entries]   = page;
            known_window_pages[mapped_entries] = next_page[PAGE_W-1:0];
            mapped_entries++;
            pages_handed_out++;
            r.virt   = {next_page[PAGE_W-1:0], addr[PAGE_SHIFT-1:0]};
            r.page   = page;
            r.status = STAT_NEW;
         end
      end
      return r;
   endfunction

   // known pages for hits (45 of 100 rolls), some edge pages, the rest fresh
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [PAGE_W-1:0] page;
      int unsigned       roll;
      roll = $urandom_range(0, 99);
      if (roll < 45 && mapped_entries > 0) begin
         page = known_phys_pages[$urandom_range(0, mapped_entries - 1)];
      end else if (roll < 57) begin
         case ($urandom_range(0, 3))
            0: page = '0;
            1: page = '1;
            2: page = 20'h80000;
            default: page = 20'h7FFFF;
         endcase
      end else begin
         page = PAGE_W'($urandom());
      end
      return {page, PAGE_SHIFT'($urandom())};
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // hold off the sender until every pending result has come back
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
   endtask

   // send one item, optionally after an idle gap
   task automatic send_item(input logic [ADDR_W-1:0] addr, input logic typed,
                            input map_result_type want);
      map_result_type predicted;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         if (req_valid) req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid     <= 1'b1;
      req_phys_addr <= addr;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predicted = map_page(addr);
      pending_maps.push_back(typed ? want : predicted);
   endtask

   // register write, then read back through the same port
   task automatic write_window(input reg_index_type idx, input logic [PAGE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_WINDOW_START) window_start_cfg = value;
      else window_end_cfg = value;
      register_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value))
         log_mismatch($sformatf("register %0d read back %h, wrote %h", idx, csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // receiver stall and result check
   always @(posedge clock) begin : result_monitor
      map_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            status_seen[rsp_status]++;
            if (pending_maps.size() == 0) begin
               log_mismatch($sformatf("unexpected result virt %h page %h status %0d",
                                      rsp_virt_addr, rsp_mapped_phys_page, rsp_status));
            end else begin
               want = pending_maps.pop_front();
               if (rsp_virt_addr !== want.virt || rsp_mapped_phys_page !== want.page ||
                   rsp_status !== want.status)
                  log_mismatch($sformatf(
                     "expected virt %h page %h status %0d, got virt %h page %h status %0d",
                     want.virt, want.page, want.status,
                     rsp_virt_addr, rsp_mapped_phys_page, rsp_status));
            end
         end
      end
   end

   // watchdog on cycles where no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no item moved for %0d cycles, %0d results pending",
                  quiet_cycles, pending_maps.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [PAGE_W-1:0] lo_page;
      logic [PAGE_W-1:0] hi_page;
      mapped_entries     = 0;
      pages_handed_out   = '0;
      window_start_cfg   = WINDOW_START_RST;
      window_end_cfg     = WINDOW_END_RST;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      mismatch_count     = 0;
      items_sent         = 0;
      register_writes    = 0;
      status_seen        = '{default: 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
            drain_results();
            write_window(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value[PAGE_W-1:0]);
         end else begin
            send_item(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
         end
      end

      // random phases, each with its own window and flow pattern
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (WINDOW_PLAN[phase])
            WIN_SMALL: begin
               lo_page = PAGE_W'($urandom_range(0, 20'hFFF00));
               hi_page = lo_page + pages_handed_out + PAGE_W'($urandom_range(2, 6));
            end
            WIN_WIDE: begin
               lo_page = '0;
               hi_page = '1;
            end
            WIN_INVERTED: begin
               lo_page = '1;
               hi_page = '0;
            end
            default: begin
               lo_page = PAGE_W'($urandom_range(0, 20'h7FFFF));
               hi_page = '1;
            end
         endcase
         write_window(REG_WINDOW_START, lo_page);
         write_window(REG_WINDOW_END, hi_page);
         case (FLOW_PLAN[phase])
            FLOW_FREE: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            FLOW_SENDER_IDLE: begin
               sender_idle_pct    = 72;
               receiver_stall_pct = 0;
            end
            FLOW_RECEIVER_STALL: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 72;
            end
            default: begin
               sender_idle_pct    = 29;
               receiver_stall_pct = 29;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then let the block run completely dry
            if ($urandom_range(0, 29) == 0) drain_results();
            send_item(pick_address(), 1'b0, '0);
         end
      end

      // wait out the last results and a full scan beyond
      drain_results();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (pending_maps.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", pending_maps.size()));
      $display("%0d lookups: %0d hits, %0d new mappings, %0d window exhausted, %0d table full",
               items_sent, status_seen[STAT_HIT], status_seen[STAT_NEW],
               status_seen[STAT_EXHAUSTED], status_seen[STAT_FULL]);
      $display("%0d window register writes, table ended with %0d of %0d entries, %0d mismatches",
               register_writes, mapped_entries, TABLE_DEPTH, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: device_page_window_mapper.f
rtl/core/dpwm_pkg.sv
rtl/core/dpwm_ram.sv
rtl/core/device_page_window_mapper.sv
bench/device_page_window_mapper_test.sv
